// ===== design/lfs_pkg.sv =====
// Link failover selector: shared types, constants and helper functions.
// Used by every module of the selector; depends on nothing.
`default_nettype none

package lfs_pkg;

    // Field widths fixed by the interface
    localparam int HEALTH_W  = 7;
    localparam int PIDX_W    = 3;
    localparam int CNT_W     = 4;
    localparam int LAT_W     = 16;
    localparam int PRIO_W    = 4;
    localparam int CFG_W     = 7;
    localparam int CFG_ADR_W = 2;

    // Number of table slots the index field can reach
    localparam int LINK_SLOTS = 2 ** PIDX_W;

    // Item kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_EVAL   = 1'b1;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_LINK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADR_W-1:0] CFG_ACTIVE_LINKS = 2'd0;
    localparam logic [CFG_ADR_W-1:0] CFG_FAIL_THRESH  = 2'd1;
    localparam logic [CFG_ADR_W-1:0] CFG_BACKUP_MIN   = 2'd2;

    // Configuration reset values
    localparam logic [CNT_W-1:0]    RST_ACTIVE_LINKS = 4'd8;
    localparam logic [CFG_W-1:0]    RST_FAIL_THRESH  = 7'd30;
    localparam logic [CFG_W-1:0]    RST_BACKUP_MIN   = 7'd50;

    // Health arithmetic constants
    localparam logic [HEALTH_W-1:0] HEALTH_FULL   = 7'd100;
    localparam logic [HEALTH_W-1:0] PEN_UNREACH   = 7'd50;
    localparam logic [HEALTH_W-1:0] PEN_LAT_100   = 7'd10;
    localparam logic [HEALTH_W-1:0] PEN_LAT_200   = 7'd25;
    localparam logic [HEALTH_W-1:0] PEN_LAT_500   = 7'd40;
    localparam logic [HEALTH_W-1:0] PEN_LAT_HIGH  = 7'd50;
    localparam logic [LAT_W-1:0]    LAT_BAND_50   = 16'd50;
    localparam logic [LAT_W-1:0]    LAT_BAND_100  = 16'd100;
    localparam logic [LAT_W-1:0]    LAT_BAND_200  = 16'd200;
    localparam logic [LAT_W-1:0]    LAT_BAND_500  = 16'd500;

    // One table entry
    typedef struct packed {
        logic              enabled;
        logic              up;
        logic              reachable;
        logic [LAT_W-1:0]  latency;
        logic [PRIO_W-1:0] prio;
    } link_entry_t;

    // Grade of one entry as produced by the shared scoring unit
    typedef struct packed {
        logic                eligible;
        logic [HEALTH_W-1:0] health;
        logic [HEALTH_W-1:0] score;
    } lfs_grade_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_RESOLVE,
        ST_FINAL
    } lfs_state_t;

    // Priority bonus: (5 - priority) * 5 for priorities below five
    function automatic logic [HEALTH_W-1:0] prio_bonus(input logic [PRIO_W-1:0] prio);
        logic [HEALTH_W-1:0] b;
        begin
            unique case (prio)
                4'd0:    b = 7'd25;
                4'd1:    b = 7'd20;
                4'd2:    b = 7'd15;
                4'd3:    b = 7'd10;
                4'd4:    b = 7'd5;
                default: b = 7'd0;
            endcase
            return b;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/lfs_grade.sv =====
// Shared scoring unit: health and selection score of one link entry.
// Depends on lfs_pkg for the entry and grade types.
`default_nettype none

module lfs_grade (
    input  var lfs_pkg::link_entry_t entry,
    output var lfs_pkg::lfs_grade_t  grade
);
    import lfs_pkg::*;

    logic [HEALTH_W-1:0] lat_pen;
    logic [HEALTH_W-1:0] reach_pen;
    logic [HEALTH_W-1:0] health;

    // Pick the latency penalty band; latency below 50 costs nothing
    always_comb begin
        priority if (entry.latency < LAT_BAND_50) begin
            lat_pen = '0;
        end else if (entry.latency < LAT_BAND_100) begin
            lat_pen = PEN_LAT_100;
        end else if (entry.latency < LAT_BAND_200) begin
            lat_pen = PEN_LAT_200;
        end else if (entry.latency < LAT_BAND_500) begin
            lat_pen = PEN_LAT_500;
        end else begin
            lat_pen = PEN_LAT_HIGH;
        end
    end

    // Penalties sum to at most the full score, so no clamp is needed
    assign reach_pen = entry.reachable ? '0 : PEN_UNREACH;
    assign health    = entry.up ? (HEALTH_FULL - reach_pen - lat_pen) : '0;

    assign grade.eligible = entry.enabled && entry.up;
    assign grade.health   = health;
    assign grade.score    = health + prio_bonus(entry.prio);

endmodule

`default_nettype wire

// ===== design/link_failover_selector_top.sv =====
// Link failover selector top level: link table, sequencer and result register.
// Depends on lfs_pkg and instantiates the shared scoring unit lfs_grade.
// An update beat also gives a result; an evaluate beat that runs a scan reads
// min(active_links, MAX_LINKS, 8) table entries, one table entry per cycle
// through the single table read port and scoring unit.
// Throughput: one beat at a time; s_ready returns once the result is registered.
// Reset (aresetn low, synchronous): table cleared, no primary, config to defaults.
`default_nettype none

module link_failover_selector_top #(
    parameter int MAX_LINKS = 8
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    // configuration write port
    input  wire                           cfg_we,
    input  wire [lfs_pkg::CFG_ADR_W-1:0]  cfg_addr,
    input  wire [lfs_pkg::CFG_W-1:0]      cfg_wdata,
    // input channel
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire                           s_kind,
    input  wire [lfs_pkg::PIDX_W-1:0]     s_link_index,
    input  wire                           s_link_enabled,
    input  wire                           s_link_up,
    input  wire                           s_link_reachable,
    input  wire [lfs_pkg::LAT_W-1:0]      s_latency_ms,
    input  wire [lfs_pkg::PRIO_W-1:0]     s_link_priority,
    // result channel
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic                          m_status,
    output logic                          m_primary_valid,
    output logic [lfs_pkg::PIDX_W-1:0]    m_primary_link,
    output logic                          m_switched,
    output logic [lfs_pkg::HEALTH_W-1:0]  m_health
);
    import lfs_pkg::*;

    // Entries past the reach of the index field stay disabled, so hold none
    localparam int TBL     = (MAX_LINKS < LINK_SLOTS) ? MAX_LINKS : LINK_SLOTS;
    localparam int IW      = $clog2(TBL);
    localparam int MAXN_I  = (MAX_LINKS > (2 ** CNT_W - 1)) ? (2 ** CNT_W - 1) : MAX_LINKS;
    localparam logic [CNT_W-1:0] MAXN = CNT_W'(MAXN_I);
    localparam logic [CNT_W-1:0] TBLN = CNT_W'(TBL);

    // Configuration registers
    logic [CNT_W-1:0]    active_reg;
    logic [CFG_W-1:0]    thr_reg;
    logic [CFG_W-1:0]    bmin_reg;

    // Link table and primary
    link_entry_t         tbl_reg [TBL];
    logic                pv_reg, pv_next;
    logic [PIDX_W-1:0]   pidx_reg, pidx_next;

    // Sequencer
    lfs_state_t          state_reg, state_next;
    logic [IW-1:0]       cnt_reg, cnt_next;
    logic [IW-1:0]       best_reg, best_next;
    logic [HEALTH_W-1:0] best_val_reg, best_val_next;
    logic                found_reg, found_next;
    logic                sel_mode_reg, sel_mode_next;
    logic                status_reg, status_next;
    logic                switched_reg, switched_next;
    logic [IW-1:0]       rd_addr_reg, rd_addr_next;
    logic                hvalid_reg, hvalid_next;

    // Result register
    logic                m_valid_reg;
    logic                m_status_reg;
    logic                m_pv_reg;
    logic [PIDX_W-1:0]   m_plink_reg;
    logic                m_switched_reg;
    logic [HEALTH_W-1:0] m_health_reg;

    // Datapath nets
    logic                in_beat;
    logic                upd_ok;
    logic [CNT_W-1:0]    n_act;
    logic [CNT_W-1:0]    scan_lim;
    logic                scan_last;
    logic                need_select;
    logic                prim_ok;
    logic                out_free;
    logic [IW-1:0]       rd_addr;
    link_entry_t         rd_entry;
    link_entry_t         wr_entry;
    lfs_grade_t          grade;
    logic                cand_ok;
    logic [HEALTH_W-1:0] cand_val;
    logic                cand_take;

    // Shared scoring unit on the table read port
    lfs_grade u_grade (
        .entry (rd_entry),
        .grade (grade)
    );

    // Derive counts and decisions
    assign in_beat     = s_valid && s_ready;
    assign upd_ok      = {1'b0, s_link_index} < TBLN;
    assign n_act       = (active_reg > MAXN) ? MAXN : active_reg;
    assign scan_lim    = (n_act > TBLN) ? TBLN : n_act;
    assign scan_last   = CNT_W'(cnt_reg) == (scan_lim - CNT_W'(1));
    assign need_select = !pv_reg || ({1'b0, pidx_reg} >= n_act);
    assign prim_ok     = grade.eligible && (grade.health >= thr_reg)
                         || (rd_entry.up && (grade.health >= thr_reg));
    assign out_free    = !m_valid_reg || m_ready;

    // Candidate test for the entry under the scan counter
    assign cand_ok   = grade.eligible
                       && (sel_mode_reg
                           || ((PIDX_W'(cnt_reg) != pidx_reg) && (grade.health >= bmin_reg)));
    assign cand_val  = sel_mode_reg ? grade.score : grade.health;
    assign cand_take = cand_ok && (!found_reg || (cand_val > best_val_reg));

    assign wr_entry = '{enabled:   s_link_enabled,
                        up:        s_link_up,
                        reachable: s_link_reachable,
                        latency:   s_latency_ms,
                        prio:      s_link_priority};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (s_kind == KIND_UPDATE || n_act == '0) begin
                        state_next = ST_FINAL;
                    end else if (need_select) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                state_next = prim_ok ? ST_FINAL : ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and read port address
    always_comb begin
        s_ready = 1'b0;
        rd_addr = rd_addr_reg;
        unique case (state_reg)
            ST_IDLE:    s_ready = 1'b1;
            ST_CHECK:   rd_addr = pidx_reg[IW-1:0];
            ST_SCAN:    rd_addr = cnt_reg;
            ST_RESOLVE: rd_addr = rd_addr_reg;
            ST_FINAL:   rd_addr = rd_addr_reg;
            default:    rd_addr = rd_addr_reg;
        endcase
    end

    assign rd_entry = tbl_reg[rd_addr];

    // Work registers of the sequencer
    always_comb begin
        pv_next       = pv_reg;
        pidx_next     = pidx_reg;
        cnt_next      = cnt_reg;
        best_next     = best_reg;
        best_val_next = best_val_reg;
        found_next    = found_reg;
        sel_mode_next = sel_mode_reg;
        status_next   = status_reg;
        switched_next = switched_reg;
        rd_addr_next  = rd_addr_reg;
        hvalid_next   = hvalid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    status_next   = STATUS_OK;
                    switched_next = 1'b0;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    sel_mode_next = 1'b1;
                    if (s_kind == KIND_UPDATE) begin
                        rd_addr_next = s_link_index[IW-1:0];
                        hvalid_next  = upd_ok;
                    end else if (n_act == '0) begin
                        status_next  = STATUS_NO_LINK;
                        rd_addr_next = pidx_reg[IW-1:0];
                        hvalid_next  = pv_reg;
                    end
                end
            end
            ST_CHECK: begin
                sel_mode_next = 1'b0;
                rd_addr_next  = pidx_reg[IW-1:0];
                hvalid_next   = 1'b1;
            end
            ST_SCAN: begin
                if (cand_take) begin
                    best_next     = cnt_reg;
                    best_val_next = cand_val;
                    found_next    = 1'b1;
                end
                cnt_next = cnt_reg + IW'(1);
            end
            ST_RESOLVE: begin
                if (found_reg) begin
                    pv_next       = 1'b1;
                    pidx_next     = PIDX_W'(best_reg);
                    switched_next = 1'b1;
                    rd_addr_next  = best_reg;
                    hvalid_next   = 1'b1;
                end else begin
                    status_next  = STATUS_NO_LINK;
                    rd_addr_next = pidx_reg[IW-1:0];
                    if (sel_mode_reg) begin
                        pv_next     = 1'b0;
                        pidx_next   = '0;
                        hvalid_next = 1'b0;
                    end else begin
                        hvalid_next = pv_reg;
                    end
                end
            end
            ST_FINAL: begin
            end
            default: begin
            end
        endcase
    end

    // Hold sequencer, primary and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pv_reg       <= 1'b0;
            pidx_reg     <= '0;
            active_reg   <= RST_ACTIVE_LINKS;
            thr_reg      <= RST_FAIL_THRESH;
            bmin_reg     <= RST_BACKUP_MIN;
            cnt_reg      <= '0;
            found_reg    <= 1'b0;
            sel_mode_reg <= 1'b1;
            hvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pv_reg       <= pv_next;
            pidx_reg     <= pidx_next;
            cnt_reg      <= cnt_next;
            found_reg    <= found_next;
            sel_mode_reg <= sel_mode_next;
            hvalid_reg   <= hvalid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_ACTIVE_LINKS: active_reg <= cfg_wdata[CNT_W-1:0];
                    CFG_FAIL_THRESH:  thr_reg    <= cfg_wdata;
                    CFG_BACKUP_MIN:   bmin_reg   <= cfg_wdata;
                    default:          ;
                endcase
            end
        end
    end

    // Payload of the sequencer
    always_ff @(posedge aclk) begin
        best_reg     <= best_next;
        best_val_reg <= best_val_next;
        status_reg   <= status_next;
        switched_reg <= switched_next;
        rd_addr_reg  <= rd_addr_next;
    end

    // Clear the table on reset and rewrite one entry on an in-range update beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TBL; i++) begin
                tbl_reg[i] <= '0;
            end
        end else if (in_beat && s_kind == KIND_UPDATE && upd_ok) begin
            tbl_reg[s_link_index[IW-1:0]] <= wr_entry;
        end
    end

    // Load the result register and drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FINAL && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINAL && out_free) begin
            m_status_reg   <= status_reg;
            m_pv_reg       <= pv_reg;
            m_plink_reg    <= pidx_reg;
            m_switched_reg <= switched_reg;
            m_health_reg   <= hvalid_reg ? grade.health : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_primary_valid = m_pv_reg;
    assign m_primary_link  = m_plink_reg;
    assign m_switched      = m_switched_reg;
    assign m_health        = m_health_reg;

endmodule

`default_nettype wire

// ===== design/lfs_checker.sv =====
// Port-level checker for the link failover selector, bound to the top level.
// Depends on lfs_pkg for widths and codes.
`default_nettype none

module lfs_port_checker (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    input  wire                           s_ready,
    input  wire                           m_valid,
    input  wire                           m_ready,
    input  wire                           m_status,
    input  wire                           m_primary_valid,
    input  wire [lfs_pkg::PIDX_W-1:0]     m_primary_link,
    input  wire                           m_switched,
    input  wire [lfs_pkg::HEALTH_W-1:0]   m_health
);
    import lfs_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_health) && $stable(m_primary_link)
                                && $stable(m_status) && $stable(m_switched))
        else $error("result beat changed while stalled");

    // One beat in flight: busy right after an accepted beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // Without a primary the link index reads zero
    a_no_primary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_primary_valid |-> (m_primary_link == '0))
        else $error("stale primary index");

    // A switch always lands on a designated primary with status ok
    a_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_switched |-> m_primary_valid && (m_status == STATUS_OK))
        else $error("switch without a primary");

    // Health stays within its scale
    a_health: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_health <= HEALTH_FULL)
        else $error("health out of range");

endmodule

bind link_failover_selector_top lfs_port_checker u_lfs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_primary_valid (m_primary_valid),
    .m_primary_link  (m_primary_link),
    .m_switched      (m_switched),
    .m_health        (m_health)
);

`default_nettype wire
